### design/multiword_integer_multiplier_core_defines.svh
// ----------------------------------------------------------------------------
// multiword integer multiplier core - assertion macros
// shared clocked assertion forms used by the core
// ----------------------------------------------------------------------------
`ifndef MULTIWORD_INTEGER_MULTIPLIER_CORE_DEFINES_SVH
`define MULTIWORD_INTEGER_MULTIPLIER_CORE_DEFINES_SVH

// plain clocked property, disabled while in reset
`define MWM_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define MWM_ASSERT_IMPLIES(label, ante, cons, msg) \
    `MWM_ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

### design/mwm_pkg.sv
// ----------------------------------------------------------------------------
// mwm_pkg
// types used by the multiword multiplier controller and datapath
// ----------------------------------------------------------------------------
package mwm_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } mwm_state_t;

    // one partial-product step issued to the datapath
    typedef struct packed {
        logic valid;
        logic col_end;
        logic last;
    } mwm_cmd_t;

endpackage

### design/mwm_ram.sv
// ----------------------------------------------------------------------------
// mwm_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/mwm_ctrl.sv
// ----------------------------------------------------------------------------
// mwm_ctrl
// request loading and column-scan sequencer for the multiword multiplier
// ----------------------------------------------------------------------------
module mwm_ctrl #(
    parameter int MAX_WORDS = 32
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 start,
    input  logic                                                 last_pair,
    input  logic                                                 pipe_busy,
    output logic                                                 busy,
    output logic                                                 wr_en,
    output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] wr_addr,
    output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] rd_addr_x,
    output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] rd_addr_y,
    output mwm_pkg::mwm_cmd_t                                    cmd
);

    localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int KW    = CNT_W + 1;

    mwm_pkg::mwm_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [CNT_W-1:0] i_reg, i_next;

    logic             accept;
    logic             store_ok;
    logic [CNT_W-1:0] count_inc;
    logic [KW-1:0]    n_ext;
    logic [KW-1:0]    i_ext;
    logic [KW-1:0]    k_inc;
    logic [KW-1:0]    i_hi;
    logic [KW-1:0]    i_lo_next;
    logic [KW-1:0]    j_idx;
    logic             last_col;
    logic             col_end;

    assign accept    = start && (state_reg == mwm_pkg::ST_IDLE);
    assign store_ok  = count_reg < CNT_W'(MAX_WORDS);
    assign count_inc = store_ok ? count_reg + CNT_W'(1) : count_reg;

    // column k collects x[i]*y[k-i] for i in [max(0,k-n+1), min(k,n-1)]
    assign n_ext     = {1'b0, n_reg};
    assign i_ext     = {1'b0, i_reg};
    assign k_inc     = k_reg + KW'(1);
    assign last_col  = k_reg == ((n_ext << 1) - KW'(1));
    assign i_hi      = (k_reg < n_ext) ? k_reg : n_ext - KW'(1);
    assign col_end   = (i_ext == i_hi) || last_col;
    assign i_lo_next = (k_inc < n_ext) ? '0 : k_inc - n_ext + KW'(1);
    assign j_idx     = k_reg - i_ext;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mwm_pkg::ST_IDLE:
            begin
                if (accept && last_pair)
                begin
                    state_next = mwm_pkg::ST_RUN;
                end
            end
            mwm_pkg::ST_RUN:
            begin
                if (last_col)
                begin
                    state_next = mwm_pkg::ST_DRAIN;
                end
            end
            mwm_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = mwm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        unique case (state_reg)
            mwm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = last_pair ? '0 : count_inc;
                    if (last_pair)
                    begin
                        n_next = count_inc;
                        k_next = '0;
                        i_next = '0;
                    end
                end
            end
            mwm_pkg::ST_RUN:
            begin
                if (col_end)
                begin
                    k_next = k_inc;
                    i_next = i_lo_next[CNT_W-1:0];
                end
                else
                begin
                    i_next = i_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        busy        = state_reg != mwm_pkg::ST_IDLE;
        wr_en       = accept && store_ok;
        wr_addr     = count_reg[AW-1:0];
        rd_addr_x   = i_reg[AW-1:0];
        rd_addr_y   = j_idx[AW-1:0];
        cmd.valid   = state_reg == mwm_pkg::ST_RUN;
        cmd.col_end = col_end;
        cmd.last    = last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mwm_pkg::ST_IDLE;
            count_reg <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
        end
    end

endmodule

### design/mwm_dpath.sv
// ----------------------------------------------------------------------------
// mwm_dpath
// operand stores, pipelined word multiplier and column accumulator
// ----------------------------------------------------------------------------
module mwm_dpath #(
    parameter int WORD_BITS = 32,
    parameter int MAX_WORDS = 32
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 wr_en,
    input  logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] wr_addr,
    input  logic [WORD_BITS-1:0]                                 x_word,
    input  logic [WORD_BITS-1:0]                                 y_word,
    input  logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] rd_addr_x,
    input  logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] rd_addr_y,
    input  mwm_pkg::mwm_cmd_t                                    cmd,
    output logic                                                 pipe_busy,
    output logic [WORD_BITS-1:0]                                 product_word,
    output logic                                                 last_word,
    output logic                                                 valid
);

    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int H     = (WORD_BITS + 1) / 2;
    localparam int L     = WORD_BITS - H;
    localparam int PW    = 2 * WORD_BITS;
    localparam int ACC_W = PW + CNT_W + 1;

    logic [WORD_BITS-1:0] x_rd, y_rd;
    logic [WORD_BITS-1:0] a_op;

    mwm_pkg::mwm_cmd_t s1_reg, s2_reg, s3_reg;

    logic [2*H-1:0]   pp00_reg;
    logic [H+L-1:0]   pp01_reg, pp10_reg;
    logic [2*L-1:0]   pp11_reg;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [ACC_W-1:0] acc_reg, acc_next, acc_sum;

    logic [WORD_BITS-1:0] product_word_reg, product_word_next;
    logic                 last_word_reg, last_word_next;
    logic                 valid_reg, valid_next;

    mwm_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_x_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (x_word),
        .raddr (rd_addr_x),
        .rdata (x_rd)
    );

    mwm_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_y_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (y_word),
        .raddr (rd_addr_y),
        .rdata (y_rd)
    );

    // the top column carries no partial product, only the final carry
    assign a_op = s1_reg.last ? '0 : x_rd;

    assign prod_next = {pp11_reg, pp00_reg}
                     + (PW'(pp01_reg) << H)
                     + (PW'(pp10_reg) << H);

    assign acc_sum = acc_reg + ACC_W'(prod_reg);

    always_comb
    begin
        acc_next          = acc_reg;
        product_word_next = product_word_reg;
        last_word_next    = 1'b0;
        valid_next        = 1'b0;
        if (s3_reg.valid)
        begin
            if (s3_reg.col_end)
            begin
                product_word_next = acc_sum[WORD_BITS-1:0];
                last_word_next    = s3_reg.last;
                valid_next        = 1'b1;
                acc_next          = s3_reg.last ? '0 : (acc_sum >> WORD_BITS);
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pp00_reg         <= a_op[H-1:0] * y_rd[H-1:0];
        pp01_reg         <= a_op[H-1:0] * y_rd[WORD_BITS-1:H];
        pp10_reg         <= a_op[WORD_BITS-1:H] * y_rd[H-1:0];
        pp11_reg         <= a_op[WORD_BITS-1:H] * y_rd[WORD_BITS-1:H];
        prod_reg         <= prod_next;
        product_word_reg <= product_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            acc_reg       <= '0;
            last_word_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            s1_reg        <= cmd;
            s2_reg        <= s1_reg;
            s3_reg        <= s2_reg;
            acc_reg       <= acc_next;
            last_word_reg <= last_word_next;
            valid_reg     <= valid_next;
        end
    end

    assign pipe_busy    = s1_reg.valid || s2_reg.valid || s3_reg.valid;
    assign product_word = product_word_reg;
    assign last_word    = last_word_reg;
    assign valid        = valid_reg;

endmodule

### design/multiword_integer_multiplier_core.sv
// ----------------------------------------------------------------------------
// multiword_integer_multiplier_core
// unsigned multiword product, operands loaded a word pair at a time
// ----------------------------------------------------------------------------
// Word pairs are taken one per cycle while busy is low, least significant
// first, and pairs beyond MAX_WORDS are dropped. The pair with last_pair
// set starts the product, and busy then stays high while a single word
// multiplier takes one partial product per cycle, scanning the product
// column by column; for n stored pairs the 2n product words come out least
// significant first as they complete, each on product_word for one cycle
// with valid high, last_word marking the most significant. Results cannot
// be held off by the receiver.
`include "multiword_integer_multiplier_core_defines.svh"

module multiword_integer_multiplier_core #(
    parameter int WORD_BITS = 32,
    parameter int MAX_WORDS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] x_word,
    input  logic [WORD_BITS-1:0] y_word,
    input  logic                 last_pair,
    output logic [WORD_BITS-1:0] product_word,
    output logic                 last_word,
    output logic                 valid
);

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr_x;
    logic [AW-1:0]     rd_addr_y;
    logic              pipe_busy;
    mwm_pkg::mwm_cmd_t cmd;

    mwm_ctrl #(.MAX_WORDS(MAX_WORDS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_pair (last_pair),
        .pipe_busy (pipe_busy),
        .busy      (busy),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_addr_x (rd_addr_x),
        .rd_addr_y (rd_addr_y),
        .cmd       (cmd)
    );

    mwm_dpath #(.WORD_BITS(WORD_BITS), .MAX_WORDS(MAX_WORDS)) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .x_word       (x_word),
        .y_word       (y_word),
        .rd_addr_x    (rd_addr_x),
        .rd_addr_y    (rd_addr_y),
        .cmd          (cmd),
        .pipe_busy    (pipe_busy),
        .product_word (product_word),
        .last_word    (last_word),
        .valid        (valid)
    );

    // results only appear inside a multiplication
    `MWM_ASSERT_IMPLIES(a_valid_busy, valid, busy, "product word outside a multiplication")

    // operand stores are never written while a product is being formed
    `MWM_ASSERT_IMPLIES(a_no_write_busy, busy, !wr_en, "operand store written while busy")

    // the block goes idle only right after the most significant word
    `MWM_ASSERT_IMPLIES(a_idle_after_last, $fell(busy), $past(valid && last_word), "early idle")

endmodule
